// ===== rtl/h2f_pkg.sv =====
// ----------------------------------------------------------------------------
// h2f_pkg
// Shared types and constants of the NAL unit to FLV video tag packetizer.
// ----------------------------------------------------------------------------
package h2f_pkg;

    localparam int BYTE_W = 8;
    localparam int TYPE_W = 5;
    localparam int LEN_W  = 24;
    localparam int SIZE_W = 25;

    localparam logic [LEN_W-1:0] POS_MAX = 24'hFFFFFF;

    // NAL unit types
    localparam logic [TYPE_W-1:0] NAL_IDR = 5'd5;
    localparam logic [TYPE_W-1:0] NAL_SPS = 5'd7;
    localparam logic [TYPE_W-1:0] NAL_PPS = 5'd8;

    // Tag body constants
    localparam logic [BYTE_W-1:0] TAG_KEY_AVC   = 8'h17;
    localparam logic [BYTE_W-1:0] TAG_INTER_AVC = 8'h27;
    localparam logic [BYTE_W-1:0] BYTE_ONE      = 8'h01;
    localparam logic [BYTE_W-1:0] BYTE_FF       = 8'hFF;
    localparam logic [BYTE_W-1:0] BYTE_E1       = 8'hE1;

    // Header lengths: fixed part of a sequence header, whole frame header
    localparam int SEQ_FIXED_LEN = 13;
    localparam int FRM_HDR_LEN   = 9;

    // Packet kinds
    localparam logic KIND_SEQ = 1'b0;
    localparam logic KIND_FRM = 1'b1;

    typedef struct packed {
        logic [BYTE_W-1:0] nal_byte;
        logic [TYPE_W-1:0] nal_type;
        logic [LEN_W-1:0]  nal_length;
        logic              nal_start;
    } nal_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              packet_kind;
        logic [SIZE_W-1:0] body_size;
        logic              last_of_packet;
    } tag_item_t;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_BURST
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;        // input transfer this cycle
        logic advance;       // emit next header byte of the burst
        logic burst_active;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic burst_req;     // current input item starts a header burst
        logic burst_last;    // burst index is on its final byte
        logic out_free;      // output register can load this cycle
    } ctrl_status_t;

endpackage

// ===== rtl/h2f_if.sv =====
// ----------------------------------------------------------------------------
// h2f_if
// Valid/ready stream interfaces for NAL input bytes and tag body output bytes.
// ----------------------------------------------------------------------------
interface h2f_nal_if
    import h2f_pkg::*;
();
    logic      valid;
    logic      ready;
    nal_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface h2f_tag_if
    import h2f_pkg::*;
();
    logic      valid;
    logic      ready;
    tag_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/h264_nal_to_flv_video_tag_core.sv =====
// ----------------------------------------------------------------------------
// h264_nal_to_flv_video_tag_core
// Packs Annex-B H.264 NAL unit bytes into FLV AVC video tag body bytes.
// ----------------------------------------------------------------------------
// Usage:
//   nal_in carries one NAL byte per transfer with its unit's type and length;
//   nal_start marks the first byte of a unit. tag_out carries one body byte
//   per transfer with packet kind, body size and a last-byte flag.
//   SPS units are stored (up to SPS_MAX bytes) and emit nothing.
//   Payload bytes of PPS and other units are registered and come out in the
//   cycle after their transfer, at one byte per cycle while tag_out takes them.
//   Byte 3 of a PPS unit starts a sequence header burst of 16 + SPS length
//   bytes; byte 2 of any other unit starts a 9-byte frame header burst. The
//   burst sequencer emits one byte per cycle while tag_out takes them and
//   holds nal_in.ready low until its last byte is loaded.
//   A single output register separates the channels: when tag_out stalls,
//   the register holds and nal_in.ready drops until it is taken.
//   Reset clears position, SPS length and the SPS store valid bits at once;
//   no clearing pass is needed and the block is ready right after reset.
// ----------------------------------------------------------------------------
module h264_nal_to_flv_video_tag_core
    import h2f_pkg::*;
#(
    parameter int SPS_MAX = 32
)
(
    input  logic             clk,
    input  logic             rst_n,
    h2f_nal_if.sink          nal_in,
    h2f_tag_if.source        tag_out
);

    ctrl_cmd_t    cmd;
    ctrl_status_t status;
    logic         in_ready;

    h2f_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (nal_in.valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    h2f_datapath #(
        .SPS_MAX (SPS_MAX)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (nal_in.data),
        .cmd       (cmd),
        .status    (status),
        .out_ready (tag_out.ready),
        .out_valid (tag_out.valid),
        .out_data  (tag_out.data)
    );

    assign nal_in.ready = in_ready;

`ifndef SYNTHESIS
    a_no_input_in_burst: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.burst_active |-> !nal_in.ready)
        else $error("input taken during header burst");

    a_advance_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.advance |-> status.out_free)
        else $error("burst advanced into a full output register");

    a_burst_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && status.burst_req) |=> cmd.burst_active)
        else $error("header burst did not start");

    a_burst_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.advance && status.burst_last) |=> !cmd.burst_active)
        else $error("header burst did not end after its last byte");
`endif

endmodule

// ===== rtl/h2f_ctrl.sv =====
// ----------------------------------------------------------------------------
// h2f_ctrl
// Sequencer: takes input bytes, or steps through a header burst.
// ----------------------------------------------------------------------------
module h2f_ctrl
    import h2f_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  ctrl_status_t status,
    output ctrl_cmd_t    cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        in_ready         = 1'b0;
        cmd.accept       = 1'b0;
        cmd.advance      = 1'b0;
        cmd.burst_active = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready   = status.out_free;
                cmd.accept = in_valid && status.out_free;
                if (cmd.accept && status.burst_req)
                begin
                    state_next = ST_BURST;
                end
            end
            ST_BURST:
            begin
                cmd.burst_active = 1'b1;
                cmd.advance      = status.out_free;
                if (status.out_free && status.burst_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/h2f_datapath.sv =====
// ----------------------------------------------------------------------------
// h2f_datapath
// Byte position tracking, SPS store, header byte generation, output register.
// ----------------------------------------------------------------------------
module h2f_datapath
    import h2f_pkg::*;
#(
    parameter int SPS_MAX = 32
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  nal_item_t    in_data,
    input  ctrl_cmd_t    cmd,
    output ctrl_status_t status,
    input  logic         out_ready,
    output logic         out_valid,
    output tag_item_t    out_data
);

    localparam int AW = (SPS_MAX > 1) ? $clog2(SPS_MAX) : 1;
    localparam int LW = $clog2(SPS_MAX + 1);
    localparam int KW = $clog2(SPS_MAX + 16);

    // ---------------- state ----------------
    logic [LEN_W-1:0]  pos_reg;
    logic              four_byte_reg;
    logic [LW-1:0]     sps_length_reg;
    logic [SPS_MAX-1:0] sps_vld_reg;
    logic [BYTE_W-1:0] sps_mem [SPS_MAX];
    logic [BYTE_W-1:0] rdata_reg;
    logic              rvld_reg;

    logic [KW-1:0]     k_reg;
    logic [KW-1:0]     k_next;
    logic [KW-1:0]     lastk_reg;
    logic              bkind_reg;
    logic [LEN_W-1:0]  bpl_reg;
    logic [SIZE_W-1:0] bsize_reg;
    logic [BYTE_W-1:0] btag_reg;

    logic              out_valid_reg;
    tag_item_t         out_item_reg;

    // ---------------- input decode ----------------
    logic [LEN_W-1:0]  p;
    logic [LEN_W-1:0]  pos_next;
    logic              in_range;
    logic              is_sps;
    logic              is_pps;
    logic              is_frm;
    logic [LEN_W-1:0]  len_less4;
    logic [LW-1:0]     sps_len_new;
    logic [SIZE_W-1:0] pps_size;
    logic              fb_new;
    logic [LEN_W-1:0]  sc;
    logic [LEN_W-1:0]  frm_pl;
    logic [SIZE_W-1:0] frm_size;
    logic              burst_req;
    logic              emit_single;
    logic              sps_wr;
    logic [LEN_W-1:0]  sps_off;

    always_comb
    begin
        p        = in_data.nal_start ? '0 : pos_reg;
        pos_next = (p < POS_MAX) ? p + 1'b1 : POS_MAX;
        in_range = p < in_data.nal_length;
        is_sps   = in_data.nal_type == NAL_SPS;
        is_pps   = in_data.nal_type == NAL_PPS;
        is_frm   = !is_sps && !is_pps;

        len_less4 = (in_data.nal_length >= LEN_W'(4)) ? in_data.nal_length - LEN_W'(4) : '0;
        sps_len_new = (len_less4 > LEN_W'(SPS_MAX)) ? LW'(SPS_MAX) : len_less4[LW-1:0];
        pps_size = SIZE_W'(16) + SIZE_W'(sps_length_reg) + SIZE_W'(len_less4);

        fb_new   = (p == LEN_W'(2)) ? (in_data.nal_byte == '0) : four_byte_reg;
        sc       = fb_new ? LEN_W'(4) : LEN_W'(3);
        frm_pl   = (in_data.nal_length > sc) ? in_data.nal_length - sc : '0;
        frm_size = SIZE_W'(FRM_HDR_LEN) + SIZE_W'(frm_pl);

        burst_req = in_range && ((is_pps && p == LEN_W'(3)) ||
                                 (is_frm && p == LEN_W'(2)));
        emit_single = in_range && ((is_pps && p >= LEN_W'(4)) || (is_frm && p >= sc));

        sps_off = p - LEN_W'(4);
        sps_wr  = in_range && is_sps && p >= LEN_W'(4) && sps_off < LEN_W'(SPS_MAX);
    end

    // ---------------- burst byte generation ----------------
    logic [KW-1:0]     sps_end;
    logic [KW-1:0]     tail;
    logic [KW-1:0]     raddr_wide;
    logic [AW-1:0]     raddr;
    logic [BYTE_W-1:0] store_byte;
    logic [15:0]       sps_len16;
    tag_item_t         burst_item;

    always_comb
    begin
        k_next = k_reg;
        if (cmd.accept && burst_req)
        begin
            k_next = '0;
        end
        else if (cmd.advance)
        begin
            k_next = k_reg + 1'b1;
        end
        // profile/compat/level bytes sit at store index 1..3
        if (k_next >= KW'(6) && k_next <= KW'(8))
        begin
            raddr_wide = k_next - KW'(5);
        end
        else
        begin
            raddr_wide = k_next - KW'(SEQ_FIXED_LEN);
        end
        raddr = (raddr_wide < KW'(SPS_MAX)) ? raddr_wide[AW-1:0] : '0;
    end

    always_comb
    begin
        sps_end    = KW'(SEQ_FIXED_LEN) + KW'(sps_length_reg);
        tail       = k_reg - sps_end;
        store_byte = rvld_reg ? rdata_reg : '0;
        sps_len16  = 16'(sps_length_reg);

        burst_item.packet_kind    = bkind_reg;
        burst_item.body_size      = bsize_reg;
        burst_item.last_of_packet = 1'b0;
        burst_item.out_byte       = '0;

        if (bkind_reg == KIND_SEQ)
        begin
            if (k_reg < KW'(SEQ_FIXED_LEN))
            begin
                case (k_reg[3:0]) inside
                    4'd0:          burst_item.out_byte = TAG_KEY_AVC;
                    [4'd1:4'd4]:   burst_item.out_byte = '0;
                    4'd5:          burst_item.out_byte = BYTE_ONE;
                    [4'd6:4'd8]:   burst_item.out_byte = store_byte;
                    4'd9:          burst_item.out_byte = BYTE_FF;
                    4'd10:         burst_item.out_byte = BYTE_E1;
                    4'd11:         burst_item.out_byte = sps_len16[15:8];
                    4'd12:         burst_item.out_byte = sps_len16[7:0];
                    default:       burst_item.out_byte = '0;
                endcase
            end
            else if (k_reg < sps_end)
            begin
                burst_item.out_byte = store_byte;
            end
            else
            begin
                case (tail[1:0])
                    2'd0:    burst_item.out_byte = BYTE_ONE;
                    2'd1:    burst_item.out_byte = bpl_reg[15:8];
                    default:
                    begin
                        burst_item.out_byte       = bpl_reg[7:0];
                        burst_item.last_of_packet = bpl_reg == '0;
                    end
                endcase
            end
        end
        else
        begin
            case (k_reg[3:0]) inside
                4'd0:        burst_item.out_byte = btag_reg;
                4'd1:        burst_item.out_byte = BYTE_ONE;
                [4'd2:4'd5]: burst_item.out_byte = '0;
                4'd6:        burst_item.out_byte = bpl_reg[23:16];
                4'd7:        burst_item.out_byte = bpl_reg[15:8];
                4'd8:
                begin
                    burst_item.out_byte       = bpl_reg[7:0];
                    burst_item.last_of_packet = bpl_reg == '0;
                end
                default:     burst_item.out_byte = '0;
            endcase
        end

        status.burst_req  = burst_req;
        status.burst_last = k_reg == lastk_reg;
        status.out_free   = !out_valid_reg || out_ready;
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= '0;
            four_byte_reg  <= 1'b0;
            sps_length_reg <= '0;
            sps_vld_reg    <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                pos_reg <= pos_next;
                if (in_range && is_sps)
                begin
                    sps_length_reg <= sps_len_new;
                end
                if (in_range && is_frm && p == LEN_W'(2))
                begin
                    four_byte_reg <= fb_new;
                end
                if (sps_wr)
                begin
                    sps_vld_reg[sps_off[AW-1:0]] <= 1'b1;
                end
            end
            if ((cmd.accept && emit_single) || cmd.advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // SPS store: one write port, one registered read port read every cycle
    always_ff @(posedge clk)
    begin
        if (cmd.accept && sps_wr)
        begin
            sps_mem[sps_off[AW-1:0]] <= in_data.nal_byte;
        end
        rdata_reg <= sps_mem[raddr];
        rvld_reg  <= sps_vld_reg[raddr];
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        if (cmd.accept && burst_req)
        begin
            if (is_pps)
            begin
                bkind_reg <= KIND_SEQ;
                bpl_reg   <= len_less4;
                bsize_reg <= pps_size;
                lastk_reg <= KW'(SEQ_FIXED_LEN + 2) + KW'(sps_length_reg);
            end
            else
            begin
                bkind_reg <= KIND_FRM;
                bpl_reg   <= frm_pl;
                bsize_reg <= frm_size;
                lastk_reg <= KW'(FRM_HDR_LEN - 1);
            end
            btag_reg <= (in_data.nal_type == NAL_IDR) ? TAG_KEY_AVC : TAG_INTER_AVC;
        end
        if (cmd.accept && emit_single)
        begin
            out_item_reg.out_byte       <= in_data.nal_byte;
            out_item_reg.packet_kind    <= is_pps ? KIND_SEQ : KIND_FRM;
            out_item_reg.body_size      <= is_pps ? pps_size : frm_size;
            out_item_reg.last_of_packet <= p == in_data.nal_length - 1'b1;
        end
        else if (cmd.advance)
        begin
            out_item_reg <= burst_item;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_item_reg;

endmodule
